FILE: rtl/hsl2rgb_pkg.sv
// Shared types and constants for the HSL to RGB converter.
// No dependencies; imported by the front, back and top-level modules.
package hsl2rgb_pkg;

    // Input item: hue in 1/16 degree, saturation and lightness in percent
    typedef struct packed {
        logic [12:0] hue_sixteenths;
        logic [6:0]  saturation_pct;
        logic [6:0]  lightness_pct;
    } hsl_t;

    // Result item: 8-bit RGB
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Classification flags carried from front to back
    typedef struct packed {
        logic sat_zero;
        logic light_low;
    } hsl2rgb_flags_t;

    localparam int FLAGS_W = $bits(hsl2rgb_flags_t);

    // Hue turn and percent limits
    localparam logic [12:0] HUE_TURN = 13'd5760;
    localparam logic [6:0]  PCT_FULL = 7'd100;
    localparam logic [6:0]  PCT_HALF = 7'd50;

    // Constant division by reciprocal multiply.
    // 5760 = 45 * 2^7 and 100 = 25 * 2^2, so the power-of-two part is folded
    // into the pre-shift and the odd part goes through the reciprocal.
    localparam int          RECIP_SHIFT   = 32;
    localparam int          HUE_PRE_SHIFT = 7;
    localparam int          HUE_DIV       = 45;
    localparam int          HUE_RECIP_W   = 27;
    localparam logic [26:0] HUE_RECIP     = 27'd95443717;   // floor(2^32 / 45)
    localparam int          PCT_PRE_SHIFT = 2;
    localparam int          PCT_DIV       = 25;
    localparam int          PCT_RECIP_W   = 28;
    localparam logic [27:0] PCT_RECIP     = 28'd171798691;  // floor(2^32 / 25)

endpackage

FILE: rtl/hsl2rgb_front.sv
// Front end of the HSL to RGB converter: accepts items, wraps and clamps them,
// and converts them to fixed-point fractions plus classification flags.
// Depends on hsl2rgb_pkg.
module hsl2rgb_front
    import hsl2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     hsl_valid,
    output logic                     hsl_ready,
    input  hsl_t                     hsl,
    output logic                     push,
    input  logic                     full,
    output logic [FRACTION_BITS-1:0] h_frac,
    output logic [FRACTION_BITS:0]   s_frac,
    output logic [FRACTION_BITS:0]   l_frac,
    output hsl2rgb_flags_t           flags
);

    localparam int F    = FRACTION_BITS;
    localparam int HX_W = 13 + F - HUE_PRE_SHIFT;
    localparam int PX_W = 7 + F - PCT_PRE_SHIFT;
    localparam int HP_W = HX_W + HUE_RECIP_W;
    localparam int PP_W = PX_W + PCT_RECIP_W;

    // Quotient of a percent value, with the one-step remainder correction
    function automatic logic [F:0] pct_frac(input logic [PP_W-1:0] prod,
                                            input logic [PX_W-1:0] x);
        logic [F:0]      q0;
        logic [PX_W-1:0] rem;
        q0  = prod[RECIP_SHIFT +: F+1];
        rem = x - PX_W'(q0) * PX_W'(PCT_DIV);
        return q0 + (F+1)'(rem >= PX_W'(PCT_DIV));
    endfunction

    logic           enable;
    logic [12:0]    hue_wrap;
    logic [6:0]     sat_clamp;
    logic [6:0]     light_clamp;
    logic [HX_W-1:0] hue_x_next;
    logic [PX_W-1:0] sat_x_next;
    logic [PX_W-1:0] light_x_next;
    logic [HP_W-1:0] hue_prod_next;
    logic [PP_W-1:0] sat_prod_next;
    logic [PP_W-1:0] light_prod_next;
    hsl2rgb_flags_t  a_flags_next;

    logic            a_valid_reg;
    logic [HX_W-1:0] hue_x_reg;
    logic [PX_W-1:0] sat_x_reg;
    logic [PX_W-1:0] light_x_reg;
    logic [HP_W-1:0] hue_prod_reg;
    logic [PP_W-1:0] sat_prod_reg;
    logic [PP_W-1:0] light_prod_reg;
    hsl2rgb_flags_t  a_flags_reg;

    logic [F-1:0]    hue_q0;
    logic [HX_W-1:0] hue_rem;
    logic [F-1:0]    h_next;
    logic [F:0]      s_next;
    logic [F:0]      l_next;

    logic            b_valid_reg;
    logic [F-1:0]    h_reg;
    logic [F:0]      s_reg;
    logic [F:0]      l_reg;
    hsl2rgb_flags_t  b_flags_reg;

    // Advance while the second stage is empty or can move into the queue
    assign enable    = !b_valid_reg || !full;
    assign hsl_ready = enable;
    assign push      = b_valid_reg && !full;

    // Wrap hue by one turn, clamp percentages, start the reciprocal multiplies
    always_comb
    begin
        hue_wrap    = (hsl.hue_sixteenths >= HUE_TURN) ? hsl.hue_sixteenths - HUE_TURN
                                                       : hsl.hue_sixteenths;
        sat_clamp   = (hsl.saturation_pct > PCT_FULL) ? PCT_FULL : hsl.saturation_pct;
        light_clamp = (hsl.lightness_pct > PCT_FULL) ? PCT_FULL : hsl.lightness_pct;

        hue_x_next   = {hue_wrap, {(F-HUE_PRE_SHIFT){1'b0}}};
        sat_x_next   = {sat_clamp, {(F-PCT_PRE_SHIFT){1'b0}}};
        light_x_next = {light_clamp, {(F-PCT_PRE_SHIFT){1'b0}}};

        hue_prod_next   = HP_W'(hue_x_next) * HP_W'(HUE_RECIP);
        sat_prod_next   = PP_W'(sat_x_next) * PP_W'(PCT_RECIP);
        light_prod_next = PP_W'(light_x_next) * PP_W'(PCT_RECIP);

        a_flags_next.sat_zero  = (sat_clamp == '0);
        a_flags_next.light_low = (light_clamp < PCT_HALF);
    end

    // Finish the divisions with a single remainder correction
    always_comb
    begin
        hue_q0  = hue_prod_reg[RECIP_SHIFT +: F];
        hue_rem = hue_x_reg - HX_W'(hue_q0) * HX_W'(HUE_DIV);
        h_next  = hue_q0 + F'(hue_rem >= HX_W'(HUE_DIV));
        s_next  = pct_frac(sat_prod_reg, sat_x_reg);
        l_next  = pct_frac(light_prod_reg, light_x_reg);
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            a_valid_reg <= hsl_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            hue_x_reg      <= hue_x_next;
            sat_x_reg      <= sat_x_next;
            light_x_reg    <= light_x_next;
            hue_prod_reg   <= hue_prod_next;
            sat_prod_reg   <= sat_prod_next;
            light_prod_reg <= light_prod_next;
            a_flags_reg    <= a_flags_next;
            h_reg          <= h_next;
            s_reg          <= s_next;
            l_reg          <= l_next;
            b_flags_reg    <= a_flags_reg;
        end
    end

    assign h_frac = h_reg;
    assign s_frac = s_reg;
    assign l_frac = l_reg;
    assign flags  = b_flags_reg;

endmodule

FILE: rtl/hsl2rgb_queue.sv
// Small flop-based FIFO between the front and back of the converter.
// No dependencies.
module hsl2rgb_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry on each push transfer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/hsl2rgb_back.sv
// Back end of the HSL to RGB converter: forms q and p, evaluates the hue ramp
// for three channels and scales to bytes, with a registered output.
// Depends on hsl2rgb_pkg.
module hsl2rgb_back
    import hsl2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     empty,
    output logic                     pop,
    input  logic [FRACTION_BITS-1:0] h_frac,
    input  logic [FRACTION_BITS:0]   s_frac,
    input  logic [FRACTION_BITS:0]   l_frac,
    input  hsl2rgb_flags_t           flags,
    output logic                     rgb_valid,
    input  logic                     rgb_ready,
    output rgb_t                     rgb
);

    localparam int F       = FRACTION_BITS;
    localparam int ONE_INT = 2 ** F;
    localparam logic [F:0]   ONE        = (F+1)'(ONE_INT);
    localparam logic [F-1:0] THIRD      = F'(ONE_INT / 3);
    localparam logic [F-1:0] SIXTH      = F'(ONE_INT / 6);
    localparam logic [F-1:0] HALF       = F'(ONE_INT / 2);
    localparam logic [F-1:0] TWO_THIRDS = F'((2 * ONE_INT) / 3);

    // Ramp segment codes
    localparam logic [1:0] SEG_RISE = 2'd0;
    localparam logic [1:0] SEG_HIGH = 2'd1;
    localparam logic [1:0] SEG_FALL = 2'd2;
    localparam logic [1:0] SEG_LOW  = 2'd3;

    // Pick the ramp segment for t and the slope multiplier operand
    function automatic logic [F+2:0] ramp_setup(input logic [F-1:0] t);
        logic [F+2:0] six_t;
        logic [F-1:0] fall_gap;
        logic [F+2:0] six_d;
        logic [1:0]   seg;
        logic [F:0]   m;
        six_t    = (F+3)'({t, 2'b00}) + (F+3)'({t, 1'b0});
        fall_gap = TWO_THIRDS - t;
        six_d    = (F+3)'({fall_gap, 2'b00}) + (F+3)'({fall_gap, 1'b0});
        seg      = SEG_LOW;
        m        = '0;
        priority if (t < SIXTH)
        begin
            seg = SEG_RISE;
            m   = six_t[F:0];
        end
        else if (t < HALF)
        begin
            seg = SEG_HIGH;
        end
        else if (t < TWO_THIRDS)
        begin
            seg = SEG_FALL;
            m   = six_d[F:0];
        end
        else
        begin
            seg = SEG_LOW;
        end
        return {seg, m};
    endfunction

    logic enable;

    // Stage 1: hue offsets and l*s product
    logic             v1_reg;
    logic [F-1:0]     t1_next [3];
    logic [F-1:0]     t1_reg  [3];
    logic [F:0]       s1_reg;
    logic [F:0]       l1_reg;
    logic [2*F+1:0]   ls_prod_next;
    logic [2*F+1:0]   ls_prod_reg;
    hsl2rgb_flags_t   flags1_reg;

    // Stage 2: q
    logic             v2_reg;
    logic [F:0]       ls;
    logic [F+1:0]     q_sum;
    logic [F:0]       q2_next;
    logic [F:0]       q2_reg;
    logic [F-1:0]     t2_reg [3];
    logic [F:0]       l2_reg;
    hsl2rgb_flags_t   flags2_reg;

    // Stage 3: p, d and ramp setup per channel
    logic             v3_reg;
    logic [F+1:0]     two_l;
    logic [F+1:0]     q_ext;
    logic [F+1:0]     p_diff;
    logic [F+1:0]     d_diff;
    logic [F:0]       p3_next;
    logic [F:0]       d3_next;
    logic [F+2:0]     setup3 [3];
    logic [F:0]       p3_reg;
    logic [F:0]       q3_reg;
    logic [F:0]       d3_reg;
    logic [F:0]       l3_reg;
    logic [1:0]       seg3_reg [3];
    logic [F:0]       m3_reg [3];
    hsl2rgb_flags_t   flags3_reg;

    // Stage 4: slope products
    logic             v4_reg;
    logic [2*F+1:0]   prod4_next [3];
    logic [2*F+1:0]   prod4_reg  [3];
    logic [1:0]       seg4_reg [3];
    logic [F:0]       p4_reg;
    logic [F:0]       q4_reg;
    logic [F:0]       l4_reg;
    hsl2rgb_flags_t   flags4_reg;

    // Stage 5: channel fractions
    logic             v5_reg;
    logic [F+1:0]     ramp_sum [3];
    logic [F:0]       chan5_next [3];
    logic [F:0]       chan5_reg  [3];

    // Output register
    logic [F+8:0]     scaled [3];
    logic [7:0]       byte_next [3];
    logic             out_valid_reg;
    rgb_t             rgb_reg;

    // Move the whole pipeline while the output register is free or taken
    assign enable    = !out_valid_reg || rgb_ready;
    assign pop       = enable && !empty;
    assign rgb_valid = out_valid_reg;
    assign rgb       = rgb_reg;

    // Stage 1: red at hue + 1/3, green at hue, blue at hue - 1/3, all mod one turn
    always_comb
    begin
        t1_next[0]   = h_frac + THIRD;
        t1_next[1]   = h_frac;
        t1_next[2]   = h_frac - THIRD;
        ls_prod_next = (2*F+2)'(l_frac) * (2*F+2)'(s_frac);
    end

    // Stage 2: q from l, s and l*s, saturated to one
    always_comb
    begin
        ls = ls_prod_reg[F +: F+1];
        if (flags1_reg.light_low)
        begin
            q_sum = (F+2)'(l1_reg) + (F+2)'(ls);
        end
        else
        begin
            q_sum = (F+2)'(l1_reg) + (F+2)'(s1_reg) - (F+2)'(ls);
        end
        q2_next = (q_sum > (F+2)'(ONE)) ? ONE : q_sum[F:0];
    end

    // Stage 3: p = 2l - q floored at zero and capped at q; d = q - p
    always_comb
    begin
        two_l  = {l2_reg, 1'b0};
        q_ext  = (F+2)'(q2_reg);
        p_diff = two_l - q_ext;
        d_diff = {q2_reg, 1'b0} - two_l;
        priority if (two_l < q_ext)
        begin
            p3_next = '0;
            d3_next = q2_reg;
        end
        else if (l2_reg > q2_reg)
        begin
            p3_next = q2_reg;
            d3_next = '0;
        end
        else
        begin
            p3_next = p_diff[F:0];
            d3_next = d_diff[F:0];
        end
        for (int c = 0; c < 3; c++)
        begin
            setup3[c] = ramp_setup(t2_reg[c]);
        end
    end

    // Stage 4: one multiplier per channel
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod4_next[c] = (2*F+2)'(d3_reg) * (2*F+2)'(m3_reg[c]);
        end
    end

    // Stage 5: select the ramp value; zero saturation gives plain lightness
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ramp_sum[c] = (F+2)'(p4_reg) + prod4_reg[c][F +: F+2];
            unique case (seg4_reg[c])
                SEG_RISE: chan5_next[c] = ramp_sum[c][F:0];
                SEG_FALL: chan5_next[c] = ramp_sum[c][F:0];
                SEG_HIGH: chan5_next[c] = q4_reg;
                SEG_LOW:  chan5_next[c] = p4_reg;
                default:  chan5_next[c] = p4_reg;
            endcase
            if (flags4_reg.sat_zero)
            begin
                chan5_next[c] = l4_reg;
            end
        end
    end

    // Output: floor(v * 255 / one), clamped to a byte
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            scaled[c]    = {chan5_reg[c], 8'b0} - (F+9)'(chan5_reg[c]);
            byte_next[c] = (scaled[c][F +: 9] > 9'd255) ? 8'd255 : scaled[c][F +: 8];
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            v1_reg        <= !empty;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            s1_reg      <= s_frac;
            l1_reg      <= l_frac;
            ls_prod_reg <= ls_prod_next;
            flags1_reg  <= flags;

            q2_reg      <= q2_next;
            l2_reg      <= l1_reg;
            flags2_reg  <= flags1_reg;

            p3_reg      <= p3_next;
            q3_reg      <= q2_reg;
            d3_reg      <= d3_next;
            l3_reg      <= l2_reg;
            flags3_reg  <= flags2_reg;

            p4_reg      <= p3_reg;
            q4_reg      <= q3_reg;
            l4_reg      <= l3_reg;
            flags4_reg  <= flags3_reg;

            for (int c = 0; c < 3; c++)
            begin
                t1_reg[c]    <= t1_next[c];
                t2_reg[c]    <= t1_reg[c];
                seg3_reg[c]  <= setup3[c][F+2:F+1];
                m3_reg[c]    <= setup3[c][F:0];
                prod4_reg[c] <= prod4_next[c];
                seg4_reg[c]  <= seg3_reg[c];
                chan5_reg[c] <= chan5_next[c];
            end

            rgb_reg.red   <= byte_next[0];
            rgb_reg.green <= byte_next[1];
            rgb_reg.blue  <= byte_next[2];
        end
    end

endmodule

FILE: rtl/hsl_to_rgb_converter_top.sv
// HSL to RGB converter, top level. Takes one HSL color per transfer and
// returns one 8-bit RGB color per transfer. Sustained rate is one color per
// clock while the receiver takes results; an item passes 2 front stages, the
// queue and 5 back stages, then the output register. The front converts to
// FRACTION_BITS fixed point and fills a QUEUE_DEPTH-entry queue; the back
// pipeline stalls only when a result sits unclaimed, and the front keeps
// accepting until the queue is full and its last stage holds an item.
// Depends on hsl2rgb_pkg, hsl2rgb_front, hsl2rgb_queue and hsl2rgb_back.
module hsl_to_rgb_converter_top
    import hsl2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int QUEUE_DEPTH   = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic hsl_valid,
    output logic hsl_ready,
    input  hsl_t hsl,
    output logic rgb_valid,
    input  logic rgb_ready,
    output rgb_t rgb
);

    localparam int F       = FRACTION_BITS;
    localparam int QUEUE_W = FLAGS_W + F + 2 * (F + 1);

    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    logic [F-1:0]       front_h;
    logic [F:0]         front_s;
    logic [F:0]         front_l;
    hsl2rgb_flags_t     front_flags;
    logic [QUEUE_W-1:0] wr_data;
    logic [QUEUE_W-1:0] rd_data;
    logic [F-1:0]       back_h;
    logic [F:0]         back_s;
    logic [F:0]         back_l;
    hsl2rgb_flags_t     back_flags;

    hsl2rgb_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsl_valid (hsl_valid),
        .hsl_ready (hsl_ready),
        .hsl       (hsl),
        .push      (push),
        .full      (full),
        .h_frac    (front_h),
        .s_frac    (front_s),
        .l_frac    (front_l),
        .flags     (front_flags)
    );

    // Pack and unpack queue entries
    assign wr_data    = {front_flags, front_h, front_s, front_l};
    assign back_flags = hsl2rgb_flags_t'(rd_data[QUEUE_W-1 -: FLAGS_W]);
    assign back_h     = rd_data[2*(F+1) +: F];
    assign back_s     = rd_data[F+1 +: F+1];
    assign back_l     = rd_data[0 +: F+1];

    hsl2rgb_queue #(
        .WIDTH (QUEUE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_data),
        .full    (full),
        .pop     (pop),
        .rd_data (rd_data),
        .empty   (empty)
    );

    hsl2rgb_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop       (pop),
        .h_frac    (back_h),
        .s_frac    (back_s),
        .l_frac    (back_l),
        .flags     (back_flags),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb       (rgb)
    );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Testbench for hsl_to_rgb_converter_top: directed and random HSL colors, predicted RGB checked
// in order by a scoreboard class. Depends on hsl2rgb_pkg and the converter RTL only.

// Scoreboard: predicts the RGB color for each input transfer and checks results in order
class rgb_scoreboard;
    localparam int FRACTION_BITS = 16;
    localparam logic [63:0] ONE        = 64'd1 << FRACTION_BITS;
    localparam logic [63:0] THIRD      = ONE / 3;
    localparam logic [63:0] SIXTH      = ONE / 6;
    localparam logic [63:0] HALF       = ONE / 2;
    localparam logic [63:0] TWO_THIRDS = (2 * ONE) / 3;

    hsl2rgb_pkg::rgb_t expected_rgb_q[$];
    int errors;

    // Piecewise-linear hue ramp between p and q at position t
    function logic [63:0] hue_ramp(logic [63:0] p, logic [63:0] q, logic [63:0] t);
        logic [63:0] d;
        d = q - p;
        if (t < SIXTH)
            return p + (d * 6 * t) / ONE;
        if (t < HALF)
            return q;
        if (t < TWO_THIRDS)
            return p + (d * 6 * (TWO_THIRDS - t)) / ONE;
        return p;
    endfunction

    // Scale a fraction to 0..255, truncating and clamping
    function logic [7:0] fraction_to_byte(logic [63:0] v);
        logic [63:0] c;
        c = (v * 255) / ONE;
        return (c > 255) ? 8'd255 : c[7:0];
    endfunction

    function hsl2rgb_pkg::rgb_t convert_hsl(hsl2rgb_pkg::hsl_t c);
        logic [63:0] hue, sat, light, h, s, l, ls, q, p, t_red, t_blue;
        hsl2rgb_pkg::rgb_t res;
        hue   = c.hue_sixteenths;
        sat   = c.saturation_pct;
        light = c.lightness_pct;
        // Fold hue into one turn, clamp percentages
        if (hue >= hsl2rgb_pkg::HUE_TURN)
            hue = hue - hsl2rgb_pkg::HUE_TURN;
        if (sat > hsl2rgb_pkg::PCT_FULL)
            sat = hsl2rgb_pkg::PCT_FULL;
        if (light > hsl2rgb_pkg::PCT_FULL)
            light = hsl2rgb_pkg::PCT_FULL;
        h = (hue * ONE) / hsl2rgb_pkg::HUE_TURN;
        s = (sat * ONE) / hsl2rgb_pkg::PCT_FULL;
        l = (light * ONE) / hsl2rgb_pkg::PCT_FULL;
        // Gray when there is no saturation
        if (sat == 0)
        begin
            res.red   = fraction_to_byte(l);
            res.green = res.red;
            res.blue  = res.red;
            return res;
        end
        ls = (l * s) / ONE;
        if (light < hsl2rgb_pkg::PCT_HALF)
            q = l + ls;
        else
            q = l + s - ls;
        if (q > ONE)
            q = ONE;
        p = (2 * l >= q) ? 2 * l - q : 64'd0;
        if (p > q)
            p = q;
        // Offset hue by a third of a turn either way, wrapping
        t_red = h + THIRD;
        if (t_red >= ONE)
            t_red = t_red - ONE;
        t_blue = (h >= THIRD) ? h - THIRD : h + ONE - THIRD;
        res.red   = fraction_to_byte(hue_ramp(p, q, t_red));
        res.green = fraction_to_byte(hue_ramp(p, q, h));
        res.blue  = fraction_to_byte(hue_ramp(p, q, t_blue));
        return res;
    endfunction

    function void note_input(hsl2rgb_pkg::hsl_t c);
        expected_rgb_q.push_back(convert_hsl(c));
    endfunction

    function void compare_channel(string name, logic [7:0] exp_val, logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
        end
    endfunction

    function void check_result(hsl2rgb_pkg::rgb_t got);
        hsl2rgb_pkg::rgb_t exp_rgb;
        if (expected_rgb_q.size() == 0)
        begin
            $error("unexpected rgb transfer: %0d %0d %0d", got.red, got.green, got.blue);
            errors++;
            return;
        end
        exp_rgb = expected_rgb_q.pop_front();
        compare_channel("red", exp_rgb.red, got.red);
        compare_channel("green", exp_rgb.green, got.green);
        compare_channel("blue", exp_rgb.blue, got.blue);
    endfunction

    function int pending();
        return expected_rgb_q.size();
    endfunction
endclass

module testbench;
    import hsl2rgb_pkg::*;

    localparam int FRACTION_BITS   = 16;
    localparam int RESET_CYCLES    = 7;
    localparam int ITEMS_PER_PHASE = 375;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 1000;

    logic clk;
    logic rst_n;
    logic hsl_valid;
    logic hsl_ready;
    hsl_t hsl;
    logic rgb_valid;
    logic rgb_ready;
    rgb_t rgb;

    int tx_idle_pct;
    int rx_stall_pct;
    bit hold_off_request;
    int quiet_cycles;

    rgb_scoreboard sb;

    hsl_to_rgb_converter_top #(
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .hsl_valid(hsl_valid),
        .hsl_ready(hsl_ready),
        .hsl      (hsl),
        .rgb_valid(rgb_valid),
        .rgb_ready(rgb_ready),
        .rgb      (rgb)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function hsl_t make_hsl(int hue, int sat, int light);
        hsl_t c;
        c.hue_sixteenths = 13'(hue);
        c.saturation_pct = 7'(sat);
        c.lightness_pct  = 7'(light);
        return c;
    endfunction

    // Mostly in-range colors with a share of out-of-range hue and percentages
    function hsl_t random_hsl();
        hsl_t c;
        int pick;
        c.hue_sixteenths = ($urandom_range(0, 99) < 85) ? 13'($urandom_range(0, 5759))
                                                        : 13'($urandom_range(5760, 8191));
        pick = $urandom_range(0, 99);
        c.saturation_pct = (pick < 10) ? 7'd0 :
                           (pick < 25) ? 7'($urandom_range(101, 127))
                                       : 7'($urandom_range(1, 100));
        pick = $urandom_range(0, 99);
        c.lightness_pct  = (pick < 5)  ? 7'd0 :
                           (pick < 10) ? 7'd100 :
                           (pick < 25) ? 7'($urandom_range(101, 127))
                                       : 7'($urandom_range(0, 100));
        return c;
    endfunction

    // Offer one color after a random gap; return at the edge where it transfers
    task send_color(input hsl_t c);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            hsl_valid <= 1'b0;
            @(negedge clk);
        end
        hsl_valid <= 1'b1;
        hsl       <= c;
        do
            @(posedge clk);
        while (!hsl_ready);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        rgb_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                rgb_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            rgb_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Monitor transfers on both channels and watch for a hang
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (hsl_valid && hsl_ready)
                    sb.note_input(hsl);
                if (rgb_valid && rgb_ready)
                    sb.check_result(rgb);
                if ((hsl_valid && hsl_ready) || (rgb_valid && rgb_ready))
                    quiet_cycles = 0;
                else
                    quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        hsl_t directed[$];
        int phase;
        sb = new;
        tx_idle_pct      = 0;
        rx_stall_pct     = 0;
        hold_off_request = 1'b0;
        rst_n     = 1'b0;
        hsl_valid = 1'b0;
        hsl       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: grays, primaries, ramp corners, wraps and clamping
        directed.push_back(make_hsl(0, 0, 0));
        directed.push_back(make_hsl(0, 0, 100));
        directed.push_back(make_hsl(2000, 0, 127));
        directed.push_back(make_hsl(0, 100, 50));
        directed.push_back(make_hsl(1920, 100, 50));
        directed.push_back(make_hsl(3840, 100, 50));
        directed.push_back(make_hsl(5759, 100, 50));
        directed.push_back(make_hsl(5760, 100, 50));
        directed.push_back(make_hsl(8191, 127, 127));
        directed.push_back(make_hsl(960, 100, 50));
        directed.push_back(make_hsl(959, 100, 50));
        directed.push_back(make_hsl(2880, 100, 50));
        directed.push_back(make_hsl(2879, 100, 50));
        directed.push_back(make_hsl(3839, 100, 50));
        directed.push_back(make_hsl(1919, 100, 50));
        directed.push_back(make_hsl(0, 101, 49));
        directed.push_back(make_hsl(100, 127, 0));
        directed.push_back(make_hsl(200, 50, 49));
        directed.push_back(make_hsl(300, 50, 50));
        directed.push_back(make_hsl(4000, 1, 1));
        directed.push_back(make_hsl(5000, 100, 100));
        directed.push_back(make_hsl(7000, 64, 33));
        directed.push_back(make_hsl(1000, 99, 99));
        directed.push_back(make_hsl(4096, 80, 20));
        foreach (directed[i])
            send_color(directed[i]);

        // Random phases: free flow with one long hold-off, slow sender, slow receiver, both
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct      = 0;
                    rx_stall_pct     = 0;
                    hold_off_request = 1'b1;
                end
                1:
                begin
                    tx_idle_pct  = 71;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 71;
                end
                default:
                begin
                    tx_idle_pct  = 20;
                    rx_stall_pct = 20;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_color(random_hsl());
        end

        // Drop valid, drain outstanding results, then settle
        @(negedge clk);
        hsl_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: files.f
rtl/hsl2rgb_pkg.sv
rtl/hsl2rgb_front.sv
rtl/hsl2rgb_queue.sv
rtl/hsl2rgb_back.sv
rtl/hsl_to_rgb_converter_top.sv
test/testbench.sv
